### rtl/core/bopen_pkg.sv
// bopen_pkg: shared types and constants for the 2x2 opening check
// no dependencies
package bopen_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int SIZE_W   = 9;
    localparam int COUNT_W  = 16;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // configuration register indexes
    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

    // result kinds
    localparam logic KIND_BLOCK   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SIZE_W-1:0]  square_row;
        logic [SIZE_W-1:0]  square_col;
        logic               covered_ok;
        logic [COUNT_W-1:0] square_count;
        logic               last;
    } result_t;

endpackage

### rtl/core/binary_opening_2x2_check_top.sv
// binary_opening_2x2_check_top: streaming check that a binary image equals its 2x2 opening
// depends on bopen_pkg; row stores are two one-bit-wide memories of MAX_WIDTH entries
// throughput: one pixel per cycle while the output queue has room, set by the
// read-modify-write of the row stores (read at accept, written back by the compute stage);
// up to two results per pixel drain one per cycle while m_ready is high
// reset: synchronous active-low aresetn clears control, position and sizes (256x256);
// row stores are not cleared, every entry is written before its contents are used
module binary_opening_2x2_check_top #(
    parameter int MAX_WIDTH  = bopen_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bopen_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_index,
    input  logic [bopen_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_kind,
    output logic [bopen_pkg::SIZE_W-1:0]   m_square_row,
    output logic [bopen_pkg::SIZE_W-1:0]   m_square_col,
    output logic                           m_covered_ok,
    output logic [bopen_pkg::COUNT_W-1:0]  m_square_count,
    output logic                           m_last
);

    localparam int CW = ($clog2(MAX_WIDTH + 1) > bopen_pkg::SIZE_W)
                        ? $clog2(MAX_WIDTH + 1) : bopen_pkg::SIZE_W;
    localparam int RW = ($clog2(MAX_HEIGHT + 1) > bopen_pkg::SIZE_W)
                        ? $clog2(MAX_HEIGHT + 1) : bopen_pkg::SIZE_W;
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PW = $clog2(FIFO_DEPTH);

    // configuration
    logic [bopen_pkg::SIZE_W-1:0] width_cfg_reg;
    logic [bopen_pkg::SIZE_W-1:0] height_cfg_reg;
    logic [CW-1:0] width_ext;
    logic [RW-1:0] height_ext;
    logic [CW-1:0] width_eff;
    logic [RW-1:0] height_eff;

    // issue side position
    logic [RW-1:0] iss_row_reg;
    logic [CW-1:0] iss_col_reg;
    logic [CW-1:0] iss_col_m1;
    logic [CW-1:0] iss_col_m2;
    logic          accept;

    // row stores
    logic pix_mem [MAX_WIDTH];
    logic blk_mem [MAX_WIDTH];
    logic pix_rd_reg;
    logic blk_rd_reg;

    // compute stage
    logic          b_valid_reg;
    logic          b_pix_reg;
    logic [RW-1:0] b_row_reg;
    logic [CW-1:0] b_col_reg;
    logic [CW-1:0] b_col_m1;
    logic [CW-1:0] b_col_m2;
    logic          b_fire;

    logic left_pix_reg;
    logic upleft_pix_reg;
    logic left_blk_reg;
    logic upleft_blk_reg;
    logic mismatch_reg;
    logic [bopen_pkg::COUNT_W-1:0] count_reg;

    logic up;
    logic old;
    logic blk;
    logic col_ge2;
    logic row_ge2;
    logic last_col;
    logic last_row;
    logic mismatch_next;
    logic [bopen_pkg::COUNT_W-1:0] count_next;

    bopen_pkg::result_t block_res;
    bopen_pkg::result_t verdict_res;

    // output queue
    bopen_pkg::result_t fifo [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fifo_cnt_reg;
    logic [1:0]    n_push;
    logic          pop;

    always_comb begin
        width_ext  = CW'(width_cfg_reg);
        height_ext = RW'(height_cfg_reg);
        if (width_ext < CW'(2)) begin
            width_eff = CW'(2);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext < RW'(2)) begin
            height_eff = RW'(2);
        end else if (height_ext > RW'(MAX_HEIGHT)) begin
            height_eff = RW'(MAX_HEIGHT);
        end else begin
            height_eff = height_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= bopen_pkg::SIZE_RESET;
            height_cfg_reg <= bopen_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bopen_pkg::CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                bopen_pkg::CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign b_fire  = b_valid_reg && (fifo_cnt_reg <= (PW+1)'(FIFO_DEPTH - 2));
    assign s_ready = !b_valid_reg || b_fire;
    assign accept  = s_valid && s_ready;

    assign iss_col_m1 = iss_col_reg - CW'(1);
    assign iss_col_m2 = iss_col_reg - CW'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_row_reg <= RW'(1);
            iss_col_reg <= CW'(1);
        end else if (accept) begin
            if (iss_col_reg >= width_eff) begin
                iss_col_reg <= CW'(1);
                if (iss_row_reg >= height_eff) begin
                    iss_row_reg <= RW'(1);
                end else begin
                    iss_row_reg <= iss_row_reg + RW'(1);
                end
            end else begin
                iss_col_reg <= iss_col_reg + CW'(1);
            end
        end
    end

    // row store read at accept, write-back from the compute stage
    assign b_col_m1 = b_col_reg - CW'(1);
    assign b_col_m2 = b_col_reg - CW'(2);

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_rd_reg <= pix_mem[iss_col_m1[AW-1:0]];
            blk_rd_reg <= blk_mem[iss_col_m2[AW-1:0]];
        end
        if (b_fire) begin
            pix_mem[b_col_m1[AW-1:0]] <= b_pix_reg;
            if (col_ge2) begin
                blk_mem[b_col_m2[AW-1:0]] <= blk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_fire) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pix_reg <= s_pixel;
            b_row_reg <= iss_row_reg;
            b_col_reg <= iss_col_reg;
        end
    end

    // window evaluation
    always_comb begin
        col_ge2  = b_col_reg >= CW'(2);
        row_ge2  = b_row_reg >= RW'(2);
        last_col = b_col_reg >= width_eff;
        last_row = b_row_reg >= height_eff;
        up  = row_ge2 && pix_rd_reg;
        old = (b_row_reg >= RW'(3)) && col_ge2 && blk_rd_reg;
        blk = col_ge2 && row_ge2 && upleft_pix_reg && up && left_pix_reg && b_pix_reg;

        mismatch_next = mismatch_reg;
        if (col_ge2) begin
            if (row_ge2) begin
                if (upleft_pix_reg != (blk | left_blk_reg | old | upleft_blk_reg)) begin
                    mismatch_next = 1'b1;
                end
                if (last_col && (up != (blk | old))) begin
                    mismatch_next = 1'b1;
                end
            end
            if (last_row) begin
                if (left_pix_reg != (blk | left_blk_reg)) begin
                    mismatch_next = 1'b1;
                end
                if (last_col && (b_pix_reg != blk)) begin
                    mismatch_next = 1'b1;
                end
            end
        end

        if (blk && (count_reg != bopen_pkg::COUNT_MAX)) begin
            count_next = count_reg + bopen_pkg::COUNT_W'(1);
        end else begin
            count_next = count_reg;
        end

        block_res.kind         = bopen_pkg::KIND_BLOCK;
        block_res.square_row   = bopen_pkg::SIZE_W'(b_row_reg - RW'(1));
        block_res.square_col   = bopen_pkg::SIZE_W'(b_col_m1);
        block_res.covered_ok   = 1'b0;
        block_res.square_count = '0;
        block_res.last         = 1'b0;

        verdict_res.kind         = bopen_pkg::KIND_VERDICT;
        verdict_res.square_row   = '0;
        verdict_res.square_col   = '0;
        verdict_res.covered_ok   = !mismatch_next;
        verdict_res.square_count = count_next;
        verdict_res.last         = 1'b1;

        n_push = {1'b0, blk} + {1'b0, (last_col && last_row)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_pix_reg   <= 1'b0;
            upleft_pix_reg <= 1'b0;
            left_blk_reg   <= 1'b0;
            upleft_blk_reg <= 1'b0;
            mismatch_reg   <= 1'b0;
            count_reg      <= '0;
        end else if (b_fire) begin
            if (last_col) begin
                left_pix_reg   <= 1'b0;
                upleft_pix_reg <= 1'b0;
                left_blk_reg   <= 1'b0;
                upleft_blk_reg <= 1'b0;
            end else begin
                left_pix_reg   <= b_pix_reg;
                upleft_pix_reg <= up;
                left_blk_reg   <= col_ge2 && blk;
                upleft_blk_reg <= col_ge2 && old;
            end
            if (last_col && last_row) begin
                mismatch_reg <= 1'b0;
                count_reg    <= '0;
            end else begin
                mismatch_reg <= mismatch_next;
                count_reg    <= count_next;
            end
        end
    end

    // output queue
    assign pop     = m_valid && m_ready;
    assign m_valid = fifo_cnt_reg != '0;

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            if (blk) begin
                fifo[wr_ptr_reg] <= block_res;
                if (n_push == 2'd2) begin
                    fifo[wr_ptr_reg + PW'(1)] <= verdict_res;
                end
            end else if (n_push != 2'd0) begin
                fifo[wr_ptr_reg] <= verdict_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (b_fire) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (b_fire ? (PW+1)'(n_push) : '0)
                            - (PW+1)'(pop);
        end
    end

    assign m_kind         = fifo[rd_ptr_reg].kind;
    assign m_square_row   = fifo[rd_ptr_reg].square_row;
    assign m_square_col   = fifo[rd_ptr_reg].square_col;
    assign m_covered_ok   = fifo[rd_ptr_reg].covered_ok;
    assign m_square_count = fifo[rd_ptr_reg].square_count;
    assign m_last         = fifo[rd_ptr_reg].last;

endmodule

### verif/tb.sv
// tb: self-checking bench for binary_opening_2x2_check_top, a 2x2 opening check on a pixel stream
// depends on bopen_pkg and the top module; a directed table runs first, then random images
// of random sizes and a widest image, their results checked against an in-bench model of the window logic
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 4;
    localparam int SMALL_PIXELS = 220;

    typedef enum bit {STEP_WRITE, STEP_PIXEL} step_op_t;
    typedef enum int {PAT_BLOCKS, PAT_BLOCKS_FLIP, PAT_NOISE, PAT_ONES, PAT_ZEROS} pat_t;

    typedef struct {
        step_op_t                      op;
        logic [0:0]                    reg_idx;
        logic [bopen_pkg::SIZE_W-1:0]  reg_val;
        bit                            pix;
        int                            n_known;
        bopen_pkg::result_t            known0;
        bopen_pkg::result_t            known1;
    } step_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [0:0]                     cfg_index = bopen_pkg::CFG_IMAGE_WIDTH;
    logic [bopen_pkg::SIZE_W-1:0]   cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_pixel = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_kind;
    logic [bopen_pkg::SIZE_W-1:0]   m_square_row;
    logic [bopen_pkg::SIZE_W-1:0]   m_square_col;
    logic                           m_covered_ok;
    logic [bopen_pkg::COUNT_W-1:0]  m_square_count;
    logic                           m_last;

    binary_opening_2x2_check_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_square_row   (m_square_row),
        .m_square_col   (m_square_col),
        .m_covered_ok   (m_covered_ok),
        .m_square_count (m_square_count),
        .m_last         (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // window model state
    logic [bopen_pkg::SIZE_W-1:0]  reg_width = bopen_pkg::SIZE_RESET;
    logic [bopen_pkg::SIZE_W-1:0]  reg_height = bopen_pkg::SIZE_RESET;
    bit                            above_pix [bopen_pkg::DEF_MAX_WIDTH];
    bit                            above_blk [bopen_pkg::DEF_MAX_WIDTH];
    bit                            w_pix, nw_pix, w_blk, nw_blk;
    int                            cur_row, cur_col;
    bit                            any_miss;
    logic [bopen_pkg::COUNT_W-1:0] found_cnt;

    bopen_pkg::result_t pending_results [$];
    step_row_t          plan [$];
    bit                 pic [0:bopen_pkg::DEF_MAX_HEIGHT-1][0:bopen_pkg::DEF_MAX_WIDTH-1];

    int  fail_count = 0;
    int  pixels_sent = 0;
    int  images_sent = 0;
    int  blocks_checked = 0;
    int  verdicts_ok = 0;
    int  verdicts_bad = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  hold_pending = 1'b0;

    function automatic int eff_size(logic [bopen_pkg::SIZE_W-1:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic bopen_pkg::result_t verdict_res(bit ok,
                                                       logic [bopen_pkg::COUNT_W-1:0] cnt);
        bopen_pkg::result_t v;
        v = '0;
        v.kind = bopen_pkg::KIND_VERDICT;
        v.covered_ok = ok;
        v.square_count = cnt;
        v.last = 1'b1;
        return v;
    endfunction

    function automatic void queue_result(bopen_pkg::result_t res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic void add_step(step_row_t s);
        plan.insert(plan.size(), s);
    endfunction

    function automatic void restart_image();
        w_pix = 0;
        nw_pix = 0;
        w_blk = 0;
        nw_blk = 0;
        cur_row = 1;
        cur_col = 1;
        any_miss = 0;
        found_cnt = '0;
    endfunction

    // one pixel through the erosion / coverage window; returns number of results
    function automatic int track_opening(bit p, output bopen_pkg::result_t r0,
                                         output bopen_pkg::result_t r1);
        int m, n, r, c, cnt;
        bit up, old, blk;
        m = eff_size(reg_width, bopen_pkg::DEF_MAX_WIDTH);
        n = eff_size(reg_height, bopen_pkg::DEF_MAX_HEIGHT);
        r = cur_row;
        c = cur_col;
        up = (r >= 2) ? above_pix[c-1] : 1'b0;
        cnt = 0;
        r0 = '0;
        r1 = '0;
        if (c >= 2) begin
            old = (r >= 3) ? above_blk[c-2] : 1'b0;
            blk = (r >= 2) && nw_pix && up && w_pix && p;
            if (r >= 2) begin
                if (nw_pix != (blk | w_blk | old | nw_blk)) any_miss = 1;
                if (c >= m && up != (blk | old)) any_miss = 1;
            end
            if (r >= n) begin
                if (w_pix != (blk | w_blk)) any_miss = 1;
                if (c >= m && p != blk) any_miss = 1;
            end
            if (blk) begin
                if (found_cnt != bopen_pkg::COUNT_MAX) found_cnt++;
                r0.kind = bopen_pkg::KIND_BLOCK;
                r0.square_row = bopen_pkg::SIZE_W'(r - 1);
                r0.square_col = bopen_pkg::SIZE_W'(c - 1);
                cnt = 1;
            end
            nw_blk = old;
            w_blk = blk;
            above_blk[c-2] = blk;
        end else begin
            w_blk = 0;
            nw_blk = 0;
        end
        above_pix[c-1] = p;
        nw_pix = up;
        w_pix = p;
        if (c >= m) begin
            if (r >= n) begin
                if (cnt == 0) r0 = verdict_res(!any_miss, found_cnt);
                else r1 = verdict_res(!any_miss, found_cnt);
                cnt++;
                restart_image();
            end else begin
                cur_row = r + 1;
                cur_col = 1;
                w_pix = 0;
                nw_pix = 0;
                w_blk = 0;
                nw_blk = 0;
            end
        end else begin
            cur_col = c + 1;
        end
        return cnt;
    endfunction

    function automatic step_row_t cfg_step(logic [0:0] idx, logic [bopen_pkg::SIZE_W-1:0] val);
        step_row_t s;
        s = '{op: STEP_WRITE, reg_idx: idx, reg_val: val, pix: 0, n_known: -1,
              known0: '0, known1: '0};
        return s;
    endfunction

    function automatic step_row_t pix_known(bit p, int n, bopen_pkg::result_t k0,
                                            bopen_pkg::result_t k1);
        step_row_t s;
        s = '{op: STEP_PIXEL, reg_idx: bopen_pkg::CFG_IMAGE_WIDTH, reg_val: '0, pix: p,
              n_known: n, known0: k0, known1: k1};
        return s;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // starts and ends on a falling edge right after the previous request
    task automatic send_pixel(bit p, int n_known, bopen_pkg::result_t k0,
                              bopen_pkg::result_t k1);
        int gap, n;
        bopen_pkg::result_t g0, g1;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
        n = track_opening(p, g0, g1);
        if (n_known >= 0) begin
            n = n_known;
            g0 = k0;
            g1 = k1;
        end
        if (n > 0) queue_result(g0);
        if (n > 1) queue_result(g1);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic set_size(logic [0:0] idx, logic [bopen_pkg::SIZE_W-1:0] val);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == bopen_pkg::CFG_IMAGE_WIDTH) reg_width = val;
        else reg_height = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_image(pat_t pat, int w, int h);
        int r, c, k, nb, dens;
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                pic[r][c] = 0;
        case (pat)
            PAT_BLOCKS, PAT_BLOCKS_FLIP: begin
                nb = $urandom_range(0, w * h / 2);
                for (k = 0; k <= nb; k++) begin
                    r = (k == 0) ? h - 2 : $urandom_range(0, h - 2);
                    c = (k == 0) ? w - 2 : $urandom_range(0, w - 2);
                    pic[r][c] = 1;
                    pic[r][c+1] = 1;
                    pic[r+1][c] = 1;
                    pic[r+1][c+1] = 1;
                end
                if (pat == PAT_BLOCKS_FLIP) begin
                    r = $urandom_range(0, h - 1);
                    c = $urandom_range(0, w - 1);
                    pic[r][c] = !pic[r][c];
                end
            end
            PAT_NOISE: begin
                dens = $urandom_range(1, 7);
                for (r = 0; r < h; r++)
                    for (c = 0; c < w; c++)
                        pic[r][c] = ($urandom_range(0, 7) < dens);
            end
            PAT_ONES: begin
                for (r = 0; r < h; r++)
                    for (c = 0; c < w; c++)
                        pic[r][c] = 1;
            end
            default: ;
        endcase
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                send_pixel(pic[r][c], -1, '0, '0);
        images_sent++;
    endtask

    function automatic pat_t pick_pattern();
        int v;
        v = $urandom_range(0, 9);
        if (v < 4) return PAT_BLOCKS;
        if (v < 6) return PAT_BLOCKS_FLIP;
        if (v < 9) return PAT_NOISE;
        return ($urandom_range(0, 1) == 0) ? PAT_ONES : PAT_ZEROS;
    endfunction

    // result checker
    always @(posedge aclk) begin
        bopen_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d row %0d col %0d count %0d",
                       m_kind, m_square_row, m_square_col, m_square_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", 16'(want.kind), 16'(m_kind));
                compare_field("square_row", 16'(want.square_row), 16'(m_square_row));
                compare_field("square_col", 16'(want.square_col), 16'(m_square_col));
                compare_field("covered_ok", 16'(want.covered_ok), 16'(m_covered_ok));
                compare_field("square_count", want.square_count, m_square_count);
                compare_field("last", 16'(want.last), 16'(m_last));
                if (want.kind == bopen_pkg::KIND_BLOCK) blocks_checked++;
                else if (want.covered_ok) verdicts_ok++;
                else verdicts_bad++;
            end
        end
    end

    // result side ready, with per-result stalls and one long hold-off
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_pending) begin
                stall = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else if (rx_quiet) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        #500_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int img_no, w_raw, h_raw, tries;
        pat_t pat;
        restart_image();

        // smallest image: all ones, a lone one, all zeros; then a 3x3 with two blocks
        add_step(cfg_step(bopen_pkg::CFG_IMAGE_WIDTH, 9'd0));
        add_step(cfg_step(bopen_pkg::CFG_IMAGE_HEIGHT, 9'd1));
        add_step(pix_known(1, 0, '0, '0));
        add_step(pix_known(1, 0, '0, '0));
        add_step(pix_known(1, 0, '0, '0));
        add_step(pix_known(1, 2, '{kind: bopen_pkg::KIND_BLOCK, square_row: 9'd1,
                                   square_col: 9'd1, default: '0},
                           verdict_res(1, 16'd1)));
        add_step(pix_known(1, 0, '0, '0));
        add_step(pix_known(0, 0, '0, '0));
        add_step(pix_known(0, 0, '0, '0));
        add_step(pix_known(0, 1, verdict_res(0, 16'd0), '0));
        add_step(pix_known(0, 0, '0, '0));
        add_step(pix_known(0, 0, '0, '0));
        add_step(pix_known(0, 0, '0, '0));
        add_step(pix_known(0, 1, verdict_res(1, 16'd0), '0));
        add_step(cfg_step(bopen_pkg::CFG_IMAGE_WIDTH, 9'd3));
        add_step(cfg_step(bopen_pkg::CFG_IMAGE_HEIGHT, 9'd3));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(0, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(0, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));
        add_step(pix_known(1, -1, '0, '0));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].op == STEP_WRITE)
                set_size(plan[i].reg_idx, plan[i].reg_val);
            else
                send_pixel(plan[i].pix, plan[i].n_known, plan[i].known0, plan[i].known1);
        end
        images_sent += 4;

        img_no = 0;
        while (pixels_sent < SMALL_PIXELS) begin
            w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            pat = pick_pattern();
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if (img_no == 1) begin
                // dense image with no sender gaps while the result side holds off
                w_raw = 8;
                h_raw = 8;
                pat = PAT_ONES;
                tx_quiet = 1'b1;
            end
            set_size(bopen_pkg::CFG_IMAGE_WIDTH, bopen_pkg::SIZE_W'(w_raw));
            set_size(bopen_pkg::CFG_IMAGE_HEIGHT, bopen_pkg::SIZE_W'(h_raw));
            if (img_no == 1) hold_pending = 1'b1;
            run_image(pat, eff_size(bopen_pkg::SIZE_W'(w_raw), bopen_pkg::DEF_MAX_WIDTH),
                      eff_size(bopen_pkg::SIZE_W'(h_raw), bopen_pkg::DEF_MAX_HEIGHT));
            img_no++;
        end

        // widest image, width reached through clamping from above, height from below
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        set_size(bopen_pkg::CFG_IMAGE_WIDTH, 9'd511);
        set_size(bopen_pkg::CFG_IMAGE_HEIGHT, 9'd0);
        run_image(($urandom_range(0, 1) == 0) ? PAT_BLOCKS : PAT_BLOCKS_FLIP,
                  bopen_pkg::DEF_MAX_WIDTH, 2);

        s_valid <= 1'b0;
        tries = 0;
        while (pending_results.size() != 0 && tries < 5000) begin
            @(negedge aclk);
            tries++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        repeat (10) @(negedge aclk);

        $display("%0d pixels in %0d images, random sizes up to 9x9 plus one 256x2 image",
                 pixels_sent, images_sent);
        $display("%0d block results, %0d clean and %0d failing verdicts checked",
                 blocks_checked, verdicts_ok, verdicts_bad);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/bopen_pkg.sv
rtl/core/binary_opening_2x2_check_top.sv
verif/tb.sv
